### rtl/htfcc_pkg.sv
`default_nettype none

package htfcc_pkg;

  // Frame layout: two data bytes followed by one CRC byte
  localparam int unsigned DATA_BYTES = 2;

  typedef logic [1:0] byte_idx_t;

  localparam byte_idx_t IDX_HIGH = 2'd0;
  localparam byte_idx_t IDX_LOW  = 2'd1;
  localparam byte_idx_t IDX_CRC  = byte_idx_t'(DATA_BYTES);

  // Measurement kinds
  localparam logic KIND_TEMP = 1'b0;
  localparam logic KIND_HUM  = 1'b1;

  // CRC-8, x^8+x^5+x^4+1, MSB first, init zero, no final xor
  localparam logic [7:0] CRC_POLY = 8'h31;

  localparam logic [15:0] STATUS_MASK = 16'hfffc;

  localparam logic [14:0] T_SCALE   = 15'd17572;
  localparam logic [15:0] T_OFFSET  = 16'd4685;
  localparam logic [6:0]  RH_SCALE  = 7'd125;
  localparam logic [7:0]  RH_OFFSET = 8'd6;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/humidity_temp_frame_crc_convert_unit.sv
`default_nettype none

// Sensor frame checker and converter.
// Input stream: one frame byte per word, high data byte, low data byte, CRC byte.
//   in_tuser[1] marks the first byte of a new frame and drops any partial one.
// A CRC-8 (poly 0x31, init zero) runs over the two data bytes. On the CRC byte
// the status bits are masked and the reading scaled: temperature to hundredths
// of a degree, humidity to whole percent. A good frame updates the held value
// of its kind; a bad one keeps the old value and reports it with crc_ok clear.
// Only the CRC byte gives an output word; data bytes give none.
// Each byte is registered in the input register, and a CRC byte's result word
// is registered in the output register.
// Throughput: one byte per cycle while no CRC byte waits on a stalled output,
// set by the combinational CRC and constant multiply between the input and output registers.
// When the receiver stalls, the result word holds; data bytes still advance,
// and a CRC byte waits in the input register, so in_tready drops only when a
// second result is ready while the first still waits.
// Reset (rst_n low, synchronous) clears both registers' valid flags, the CRC,
// the byte position, the stored data bytes and both held values.
module humidity_temp_frame_crc_convert_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic [1:0]  in_tuser,   // [0] kind, [1] frame_start
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [14:0] value, [22:15] computed_crc, [23] zero
  output logic [1:0]       out_tuser   // [0] result_kind, [1] crc_ok
);

  // input register
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_kind_r;
  logic       in_start_r;

  // frame state
  logic [7:0]              crc_r, crc_nxt;
  htfcc_pkg::byte_idx_t    byte_index_r, byte_index_nxt;
  logic [7:0]              high_r, high_nxt;
  logic [7:0]              low_r, low_nxt;
  logic [14:0]             held_temp_r, held_temp_nxt;
  logic [7:0]              held_hum_r, held_hum_nxt;

  // output register
  logic        out_valid_r;
  logic [14:0] out_value_r, out_value_nxt;
  logic [7:0]  out_crc_r;
  logic        out_kind_r;
  logic        out_ok_r;

  htfcc_pkg::byte_idx_t idx_eff;
  logic        is_crc;
  logic        adv;
  logic        crc_ok;
  logic [7:0]  crc_base;
  logic [15:0] raw;
  logic [30:0] t_prod;
  logic [22:0] h_prod;
  logic [15:0] t_val;
  logic [7:0]  h_val;

  // A start flag or an out-of-range position restarts the frame
  assign idx_eff = (in_start_r || (byte_index_r > htfcc_pkg::IDX_CRC)) ?
                   htfcc_pkg::IDX_HIGH : byte_index_r;
  assign is_crc  = (idx_eff == htfcc_pkg::IDX_CRC);

  // Data bytes never wait; a CRC byte waits for room in the output register
  assign adv       = in_valid_r && (!is_crc || !out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;

  assign crc_base = (idx_eff == htfcc_pkg::IDX_HIGH) ? 8'd0 : crc_r;
  assign crc_ok   = (in_byte_r == crc_r);

  // Scale the masked reading
  assign raw    = {high_r, low_r} & htfcc_pkg::STATUS_MASK;
  assign t_prod = {15'd0, raw} * {16'd0, htfcc_pkg::T_SCALE};
  assign h_prod = {7'd0, raw} * {16'd0, htfcc_pkg::RH_SCALE};
  assign t_val  = {1'b0, t_prod[30:16]} - htfcc_pkg::T_OFFSET;
  assign h_val  = {1'b0, h_prod[22:16]} - htfcc_pkg::RH_OFFSET;

  always_comb begin
    crc_nxt        = crc_r;
    byte_index_nxt = byte_index_r;
    high_nxt       = high_r;
    low_nxt        = low_r;
    held_temp_nxt  = held_temp_r;
    held_hum_nxt   = held_hum_r;
    if (adv) begin
      if (is_crc) begin
        byte_index_nxt = htfcc_pkg::IDX_HIGH;
        if (crc_ok) begin
          if (in_kind_r == htfcc_pkg::KIND_TEMP) begin
            held_temp_nxt = t_val[14:0];
          end else begin
            held_hum_nxt = h_val;
          end
        end
      end else begin
        crc_nxt        = htfcc_pkg::crc8_byte(crc_base, in_byte_r);
        byte_index_nxt = idx_eff + 2'd1;
        if (idx_eff == htfcc_pkg::IDX_HIGH) begin
          high_nxt = in_byte_r;
        end else begin
          low_nxt = in_byte_r;
        end
      end
    end
  end

  // Report the held value of this kind after any update; humidity sign-extends
  always_comb begin
    if (in_kind_r == htfcc_pkg::KIND_TEMP) begin
      out_value_nxt = held_temp_nxt;
    end else begin
      out_value_nxt = {{7{held_hum_nxt[7]}}, held_hum_nxt};
    end
  end

  // Input register: load a word whenever the slot is free or moving on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
    if (in_tvalid && in_tready) begin
      in_byte_r  <= in_tdata;
      in_kind_r  <= in_tuser[0];
      in_start_r <= in_tuser[1];
    end
  end

  // Frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r        <= 8'd0;
      byte_index_r <= htfcc_pkg::IDX_HIGH;
      high_r       <= 8'd0;
      low_r        <= 8'd0;
      held_temp_r  <= 15'd0;
      held_hum_r   <= 8'd0;
    end else begin
      crc_r        <= crc_nxt;
      byte_index_r <= byte_index_nxt;
      high_r       <= high_nxt;
      low_r        <= low_nxt;
      held_temp_r  <= held_temp_nxt;
      held_hum_r   <= held_hum_nxt;
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && is_crc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (adv && is_crc) begin
      out_value_r <= out_value_nxt;
      out_crc_r   <= crc_r;
      out_kind_r  <= in_kind_r;
      out_ok_r    <= crc_ok;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_crc_r, out_value_r};
  assign out_tuser  = {out_ok_r, out_kind_r};

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    byte_index_r != 2'd3)
    else $error("byte position out of range");

  a_crc_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
    adv && is_crc |=> out_valid_r)
    else $error("CRC byte did not load a result word");

  a_data_advances: assert property (@(posedge clk) disable iff (!rst_n)
    adv && !is_crc |=> byte_index_r != htfcc_pkg::IDX_HIGH)
    else $error("data byte did not advance frame position");

  a_stall_only_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> in_valid_r && is_crc && out_valid_r && !out_tready)
    else $error("input stalled without a blocked result");
`endif

endmodule

`default_nettype wire
